>>> rtl/pidfd_pkg.sv
// Package for the filtered-derivative PID core.
// Holds the serial unit widths, status codes and saturation helpers.
// No dependencies.
package pidfd_pkg;

    localparam int MulW     = 34;   // signed operand width of the serial multiplier
    localparam int ProdW    = 2 * MulW;
    localparam int DivNumW  = 52;   // signed dividend width of the serial divider
    localparam int DivDenW  = 33;   // unsigned divisor width
    localparam int QW       = 32;

    localparam logic [1:0] StatNone = 2'd0;
    localparam logic [1:0] StatMin  = 2'd1;
    localparam logic [1:0] StatMax  = 2'd2;

    localparam logic [2:0] RegGainP  = 3'd0;
    localparam logic [2:0] RegGainI  = 3'd1;
    localparam logic [2:0] RegGainD  = 3'd2;
    localparam logic [2:0] RegPeriod = 3'd3;
    localparam logic [2:0] RegTau    = 3'd4;
    localparam logic [2:0] RegOutMin = 3'd5;
    localparam logic [2:0] RegOutMax = 3'd6;
    localparam logic [2:0] RegMode   = 3'd7;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        logic signed [31:0] r;
        if (x > 52'sh0_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -52'sh0_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/pidfd_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle (shift and add).
// Depends on pidfd_pkg.
module pidfd_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [pidfd_pkg::MulW-1:0]    i_a,
    input  logic signed [pidfd_pkg::MulW-1:0]    i_b,
    output logic                                 o_done,
    output logic signed [pidfd_pkg::ProdW-1:0]   o_prod
);
    localparam int W = pidfd_pkg::MulW;

    logic [2*W-1:0] r_acc, n_acc;
    logic [W-1:0]   r_mcand;
    logic           r_neg, r_busy, r_done;
    logic [5:0]     r_cnt;
    logic [W:0]     sum;
    logic [W-1:0]   mag_a, mag_b;

    assign mag_a = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign mag_b = i_b[W-1] ? W'(-i_b) : W'(i_b);

    always_comb begin
        sum   = {1'b0, r_acc[2*W-1:W]} + (r_acc[0] ? {1'b0, r_mcand} : {(W+1){1'b0}});
        n_acc = {sum, r_acc[W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc   <= {{W{1'b0}}, mag_b};
                r_mcand <= mag_a;
                r_neg   <= i_a[W-1] ^ i_b[W-1];
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);
endmodule

>>> rtl/pidfd_div.sv
// Restoring divider, one quotient bit per cycle: sat32(trunc(num * 2^16 / den)).
// Depends on pidfd_pkg.
module pidfd_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pidfd_pkg::DivNumW-1:0]   i_num,
    input  logic [pidfd_pkg::DivDenW-1:0]          i_den,
    output logic                                   o_done,
    output logic signed [31:0]                     o_quo
);
    localparam int NW = pidfd_pkg::DivNumW;
    localparam int DW = pidfd_pkg::DivDenW;
    localparam int BW = NW + 16;

    logic [NW-1:0]  mag;
    logic [BW-1:0]  big;
    logic [BW-DW-1:0] rem0;
    logic [DW-1:0]  r_rem, r_den;
    logic [DW-1:0]  r_q;
    logic           r_neg, r_ovf, r_busy, r_done;
    logic [5:0]     r_cnt;
    logic [DW:0]    trial;
    logic           ge, sat_hi;

    assign mag   = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign big   = {mag, 16'd0};
    assign rem0  = big[BW-1:DW];
    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // quotient would need more than DW bits: saturate at once
                r_ovf  <= rem0 >= (BW-DW)'(i_den);
                r_rem  <= rem0[DW-1:0];
                r_q    <= big[DW-1:0];
                r_den  <= i_den;
                r_neg  <= i_num[NW-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign sat_hi = r_ovf | r_q[DW-1];

    always_comb begin
        if (r_neg) begin
            if (sat_hi || (r_q[31:0] > 32'h8000_0000)) o_quo = 32'sh8000_0000;
            else                                        o_quo = -$signed(r_q[31:0]);
        end else begin
            if (sat_hi || r_q[31]) o_quo = 32'sh7FFF_FFFF;
            else                   o_quo = $signed(r_q[31:0]);
        end
    end

    assign o_done = r_done;
endmodule

>>> rtl/pid_filtered_derivative_core.sv
// PID controller core with trapezoidal integral and selectable derivative term.
// Depends on pidfd_pkg, pidfd_mul and pidfd_div.
//
// One item at a time. An item is computed by one bit-serial 34-bit multiplier
// and one restoring divider, used in a fixed sequence. Filtered mode needs five
// products and plain mode needs four; each mode needs one division. The
// result waits in the last step until the output register is free, so a
// stalled sink adds its stall to the item. The input is ready again in the
// same cycle as the result enters the output register.
module pid_filtered_derivative_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // target_value [31:0], measured_value [63:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // drive_value [31:0], clamp_status [33:32], zero
);
    localparam int MW = pidfd_pkg::MulW;
    localparam int PW = pidfd_pkg::ProdW;
    localparam int NW = pidfd_pkg::DivNumW;
    localparam int DW = pidfd_pkg::DivDenW;

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StP    = 4'd1;
    localparam logic [3:0] StKit  = 4'd2;
    localparam logic [3:0] StInt  = 4'd3;
    localparam logic [3:0] StA    = 4'd4;
    localparam logic [3:0] StB    = 4'd5;
    localparam logic [3:0] StDiv  = 4'd6;
    localparam logic [3:0] StRate = 4'd7;
    localparam logic [3:0] StDp   = 4'd8;
    localparam logic [3:0] StSum  = 4'd9;

    logic signed [31:0] r_gain_p, r_gain_i, r_gain_d, r_out_min, r_out_max;
    logic [30:0]        r_period, r_tau;
    logic               r_mode;

    logic signed [31:0] r_integral, r_dterm, r_last_err, r_last_meas;
    logic signed [31:0] r_mv, r_err, r_d;
    logic signed [47:0] r_p;
    logic signed [49:0] r_a;
    logic [3:0]         r_state;

    logic               r_mstart, r_dstart;
    logic signed [MW-1:0] r_ma, r_mb;
    logic signed [NW-1:0] r_dnum;
    logic [DW-1:0]      r_dden;
    logic               mdone, ddone;
    logic signed [PW-1:0] prod;
    logic signed [31:0] dquo;

    logic               r_ovalid;
    logic signed [31:0] r_drive;
    logic [1:0]         r_status;

    logic signed [31:0] sp, mv, err_sat, kit_sat;
    logic signed [32:0] err_full;
    logic [30:0]        t_eff;
    logic signed [51:0] kit_full;
    logic signed [51:0] int_next, dp_full;
    logic signed [50:0] num;
    logic signed [49:0] total;
    logic               accept;

    assign sp       = i_s_tdata[31:0];
    assign mv       = i_s_tdata[63:32];
    assign err_full = {sp[31], sp} - {mv[31], mv};
    assign err_sat  = pidfd_pkg::sat32(NW'(err_full));
    assign t_eff    = (r_period == 31'd0) ? 31'd1 : r_period;
    assign accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == StIdle);

    assign kit_full = NW'($signed(prod[PW-1:16]));
    always_comb begin
        if (kit_full > 52'sh0_0000_7FFF_FFFF)       kit_sat = 32'sh7FFF_FFFF;
        else if (kit_full < -52'sh0_0000_7FFF_FFFF) kit_sat = -32'sh7FFF_FFFF;
        else                                        kit_sat = kit_full[31:0];
    end
    assign int_next = NW'(r_integral) + NW'($signed(prod[64:17]));
    assign num      = 51'(r_a) + 51'($signed(prod[63:16]));
    assign dp_full  = NW'($signed(prod[63:16]));
    assign total    = 50'(r_p) + 50'(r_integral) + 50'(r_d);

    pidfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mdone),
        .o_prod  (prod)
    );

    pidfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (ddone),
        .o_quo   (dquo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_period    <= 31'd65536;
            r_tau       <= '0;
            r_out_min   <= 32'sh8000_0000;
            r_out_max   <= 32'sh7FFF_FFFF;
            r_mode      <= 1'b1;
            r_integral  <= '0;
            r_dterm     <= '0;
            r_last_err  <= '0;
            r_last_meas <= '0;
            r_state     <= StIdle;
            r_mstart    <= 1'b0;
            r_dstart    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            r_dstart <= 1'b0;
            // the last step reloads the output register itself
            if (r_ovalid && i_m_tready && r_state != StSum) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidfd_pkg::RegGainP:  r_gain_p  <= i_cfg_data;
                    pidfd_pkg::RegGainI:  r_gain_i  <= i_cfg_data;
                    pidfd_pkg::RegGainD:  r_gain_d  <= i_cfg_data;
                    pidfd_pkg::RegPeriod: r_period  <= i_cfg_data[30:0];
                    pidfd_pkg::RegTau:    r_tau     <= i_cfg_data[30:0];
                    pidfd_pkg::RegOutMin: r_out_min <= i_cfg_data;
                    pidfd_pkg::RegOutMax: r_out_max <= i_cfg_data;
                    pidfd_pkg::RegMode:   r_mode    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            case (r_state)
                StIdle: begin
                    if (accept) begin
                        r_mv     <= mv;
                        r_err    <= err_sat;
                        r_ma     <= MW'(err_sat);
                        r_mb     <= MW'(r_gain_p);
                        r_mstart <= 1'b1;
                        r_state  <= StP;
                    end
                end
                StP: begin
                    if (mdone) begin
                        r_p      <= prod[63:16];
                        r_ma     <= MW'(r_gain_i);
                        r_mb     <= MW'($signed({1'b0, t_eff}));
                        r_mstart <= 1'b1;
                        r_state  <= StKit;
                    end
                end
                StKit: begin
                    if (mdone) begin
                        r_ma     <= MW'(kit_sat);
                        r_mb     <= MW'(r_err) + MW'(r_last_err);
                        r_mstart <= 1'b1;
                        r_state  <= StInt;
                    end
                end
                StInt: begin
                    if (mdone) begin
                        r_integral <= pidfd_pkg::sat32(int_next);
                        if (r_mode) begin
                            r_ma     <= MW'(r_gain_d);
                            r_mb     <= MW'(r_mv) - MW'(r_last_meas);
                            r_mstart <= 1'b1;
                            r_state  <= StA;
                        end else begin
                            r_dnum   <= NW'(r_err) - NW'(r_last_err);
                            r_dden   <= DW'(t_eff);
                            r_dstart <= 1'b1;
                            r_state  <= StRate;
                        end
                    end
                end
                StA: begin
                    if (mdone) begin
                        r_a      <= prod[64:15];
                        r_ma     <= MW'({r_tau, 1'b0}) - MW'(t_eff);
                        r_mb     <= MW'(r_dterm);
                        r_mstart <= 1'b1;
                        r_state  <= StB;
                    end
                end
                StB: begin
                    if (mdone) begin
                        r_dnum   <= -NW'(num);
                        r_dden   <= DW'({r_tau, 1'b0}) + DW'(t_eff);
                        r_dstart <= 1'b1;
                        r_state  <= StDiv;
                    end
                end
                StDiv: begin
                    if (ddone) begin
                        r_d     <= dquo;
                        r_state <= StSum;
                    end
                end
                StRate: begin
                    if (ddone) begin
                        r_ma     <= MW'(r_gain_d);
                        r_mb     <= MW'(dquo);
                        r_mstart <= 1'b1;
                        r_state  <= StDp;
                    end
                end
                StDp: begin
                    if (mdone) begin
                        r_d     <= pidfd_pkg::sat32(dp_full);
                        r_state <= StSum;
                    end
                end
                StSum: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_m_tready) begin
                        if (total > 50'(r_out_max)) begin
                            r_drive  <= r_out_max;
                            r_status <= pidfd_pkg::StatMax;
                        end else if (total < 50'(r_out_min)) begin
                            // crossed limits land on the maximum
                            if (r_out_min > r_out_max) begin
                                r_drive  <= r_out_max;
                                r_status <= pidfd_pkg::StatMax;
                            end else begin
                                r_drive  <= r_out_min;
                                r_status <= pidfd_pkg::StatMin;
                            end
                        end else begin
                            r_drive  <= total[31:0];
                            r_status <= pidfd_pkg::StatNone;
                        end
                        r_ovalid    <= 1'b1;
                        r_dterm     <= r_d;
                        r_last_err  <= r_err;
                        r_last_meas <= r_mv;
                        r_state     <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_status, r_drive};
endmodule

>>> rtl/pidfd_chk.sv
// Port-level checker for the PID core, bound to the top level.
// Depends on pid_filtered_derivative_core's ports only.
module pidfd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[33:32] != 2'd3)
        else $error("illegal clamp status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted while busy");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("result shown while still busy");
endmodule

bind pid_filtered_derivative_core pidfd_chk u_pidfd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
